// ===== hw/rtl/pse_pkg.sv =====
// Shared types and constants of the probability sort engine.
package pse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_BITS  = 16;
    localparam int TAG_BITS  = 9;
    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);

    typedef struct packed {
        logic [15:0] item_key;
        logic [8:0]  item_tag;
        logic        is_last;
    } item_t;

    typedef struct packed {
        logic [15:0] sorted_key;
        logic [8:0]  sorted_tag;
        logic        last_out;
        logic        overflow;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        entry_t              new_entry;
        logic [CNT_BITS-1:0] count;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/probability_sort_engine_unit.sv =====
// Top level of the probability sort engine: insertion chain and load/emit control.
//
// The engine collects a list of up to MAX_ITEMS (key, tag) beats and returns them in
// ascending key order, with equal keys in arrival order. Loading takes one input beat
// per clock: every beat is placed at once into a chain of cells that is always kept
// sorted, each cell comparing the new key with its own and handing its entry to the
// next cell up when the new key belongs below it. The beat marked last ends the list;
// from the following cycle, while the output is not stalled, the chain shifts down
// one cell per cycle and emits one result beat per clock from its bottom cell. No
// input beat is taken while a run is being emitted; the next list may start in the
// cycle after the final result beat. Beats that arrive while the chain is full are
// dropped, and every result beat of that run carries overflow set. A run always
// holds at least one item.
module probability_sort_engine_unit
    import pse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    item_valid,
    output logic    item_ready,
    output result_t result,
    output logic    result_valid,
    input  logic    result_ready
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                dropped_reg;
    logic                dropped_next;

    cell_ctrl_t ctrl;
    entry_t     cell_entry [MAX_ITEMS];
    logic       cell_gt    [MAX_ITEMS];

    logic item_fire;
    logic result_fire;
    logic full;

    assign item_ready   = (state_reg == ST_LOAD);
    assign result_valid = (state_reg == ST_EMIT);
    assign item_fire    = item_valid && item_ready;
    assign result_fire  = result_valid && result_ready;
    assign full         = (count_reg == CNT_BITS'(MAX_ITEMS));

    // Control broadcast to every cell of the chain.
    always_comb
    begin
        ctrl.op                  = OP_HOLD;
        ctrl.new_entry.key       = KEY_BITS'(item.item_key);
        ctrl.new_entry.tag       = item.item_tag;
        ctrl.count               = count_reg;
        if (item_fire && !full)
        begin
            ctrl.op = OP_INSERT;
        end
        else if (result_fire)
        begin
            ctrl.op = OP_SHIFT;
        end
    end

    // The chain: each cell sees the entry below it for inserts and above it for shifts.
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic   prev_gt;
        entry_t down_entry;
        entry_t up_entry;

        if (i == 0)
        begin : g_bottom
            assign prev_gt    = 1'b0;
            assign down_entry = '0;
        end
        else
        begin : g_mid
            assign prev_gt    = cell_gt[i-1];
            assign down_entry = cell_entry[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_top
            assign up_entry = '0;
        end
        else
        begin : g_below
            assign up_entry = cell_entry[i+1];
        end

        pse_cell u_cell (
            .clk        (clk),
            .index      (CNT_BITS'(i)),
            .ctrl       (ctrl),
            .prev_gt    (prev_gt),
            .down_entry (down_entry),
            .up_entry   (up_entry),
            .gt         (cell_gt[i]),
            .entry      (cell_entry[i])
        );
    end

    // Sequencer: count tracks the filled cells in both phases.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_fire)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                    end
                    if (item.is_last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (result_fire)
                begin
                    count_next = count_reg - CNT_BITS'(1);
                    if (count_reg == CNT_BITS'(1))
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // The bottom cell is a register, so the result beat comes straight from it.
    assign result.sorted_key = 16'(cell_entry[0].key);
    assign result.sorted_tag = cell_entry[0].tag;
    assign result.last_out   = (count_reg == CNT_BITS'(1));
    assign result.overflow   = dropped_reg;

`ifndef ASSERT_OFF
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (count_reg != '0))
        else $error("emitting with an empty chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_ITEMS))
        else $error("item count above capacity");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.is_last) |=> (result_valid && !item_ready))
        else $error("last item did not start emission");

    a_drop_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && full) |=> dropped_reg)
        else $error("dropped item not flagged");
`endif

endmodule

// ===== hw/rtl/pse_cell.sv =====
// One cell of the sorting chain: holds one entry and trades it with its neighbors.
module pse_cell
    import pse_pkg::*;
(
    input  logic                clk,
    input  logic [CNT_BITS-1:0] index,
    input  cell_ctrl_t          ctrl,
    input  logic                prev_gt,
    input  entry_t              down_entry,
    input  entry_t              up_entry,
    output logic                gt,
    output entry_t              entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // An empty cell counts as holding a key above every real key.
    assign gt = (index >= ctrl.count) || (entry_reg.key > ctrl.new_entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (gt)
                begin
                    entry_next = prev_gt ? down_entry : ctrl.new_entry;
                end
            end
            OP_SHIFT:
            begin
                entry_next = up_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== bench/probability_sort_engine_unit_test.sv =====
// Self-checking bench for the probability sort engine: ascending order, stable ties, overflow.
module probability_sort_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pse_pkg::*;

    // The watchdog trips after this many cycles in which neither side accepts a beat.
    // The slowest correct flow waits only for a sender gap or a receiver stall between
    // two beats, so this is many times the worst honest wait.
    localparam int IDLE_LIMIT  = 1000;
    // After the last expected result, watch this long for anything extra coming out.
    localparam int TAIL_CYCLES = MAX_ITEMS + 16;

    // How the keys of a generated list are spread.
    typedef enum int unsigned
    {
        SPREAD_FULL,
        SPREAD_TIES,
        SPREAD_EDGES
    } key_spread_t;

    // One input beat waiting to be sent, with its gap before it and whether the
    // sender must hold it back until every expected result has been delivered.
    typedef struct
    {
        item_t       beat;
        int unsigned gap;
        bit          drain_first;
    } queued_beat_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    item_t   item_beat    = '0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    result_t result_beat;
    logic    result_valid;
    logic    result_ready = 1'b0;

    // Handshake outcomes of the most recent rising edge, read at the falling edge.
    logic item_taken   = 1'b0;
    logic result_taken = 1'b0;

    queued_beat_t send_queue [$];
    int unsigned  gap_left    = 0;
    int unsigned  stall_left  = 0;
    int unsigned  stall_now   = 0;
    bit           steady_sink = 1'b0;

    // Our own copy of the insertion chain: entries below chain_fill are valid and sorted.
    logic [15:0]  chain_keys [MAX_ITEMS];
    logic [8:0]   chain_tags [MAX_ITEMS];
    int unsigned  chain_fill = 0;
    bit           chain_lost = 1'b0;
    result_t      due_results [$];

    int unsigned  idle_cycles     = 0;
    int unsigned  mismatches      = 0;
    int unsigned  beats_taken     = 0;
    int unsigned  results_checked = 0;
    int unsigned  runs_done       = 0;
    int unsigned  overflow_runs   = 0;

    probability_sort_engine_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_beat),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result_beat),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Places an accepted beat into the sorted chain. A key moves below every stored key
    // that is strictly greater, so equal keys keep their arrival order. When the chain
    // is full the beat is lost and the run is marked. A last beat releases the whole
    // chain as expected results and empties it for the next list.
    task automatic place_beat(item_t b);
        int unsigned pos;
        int unsigned i;
        result_t     r;
        if (chain_fill < MAX_ITEMS)
        begin
            pos = chain_fill;
            while (pos > 0 && chain_keys[pos - 1] > b.item_key)
            begin
                chain_keys[pos] = chain_keys[pos - 1];
                chain_tags[pos] = chain_tags[pos - 1];
                pos--;
            end
            chain_keys[pos] = b.item_key;
            chain_tags[pos] = b.item_tag;
            chain_fill++;
        end
        else
        begin
            chain_lost = 1'b1;
        end
        if (b.is_last)
        begin
            for (i = 0; i < chain_fill; i++)
            begin
                r.sorted_key = chain_keys[i];
                r.sorted_tag = chain_tags[i];
                r.last_out   = (i + 1 == chain_fill);
                r.overflow   = chain_lost;
                due_results.push_back(r);
            end
            if (chain_lost)
                overflow_runs++;
            runs_done++;
            chain_fill = 0;
            chain_lost = 1'b0;
        end
    endtask

    // Compares one delivered result with the oldest expected one, field by field.
    task automatic check_result(result_t got);
        result_t want;
        results_checked++;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result key %h tag %h arrived with nothing expected",
                                      got.sorted_key, got.sorted_tag));
            return;
        end
        want = due_results.pop_front();
        if (got.sorted_key !== want.sorted_key)
            report_mismatch($sformatf("sorted_key %h, expected %h",
                                      got.sorted_key, want.sorted_key));
        if (got.sorted_tag !== want.sorted_tag)
            report_mismatch($sformatf("sorted_tag %h, expected %h (key %h)",
                                      got.sorted_tag, want.sorted_tag, want.sorted_key));
        if (got.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, expected %b (key %h)",
                                      got.last_out, want.last_out, want.sorted_key));
        if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b (key %h)",
                                      got.overflow, want.overflow, want.sorted_key));
    endtask

    task automatic add_beat(logic [15:0] key, logic [8:0] tag, bit last, bit steady,
                            bit drain);
        queued_beat_t q;
        q.beat.item_key = key;
        q.beat.item_tag = tag;
        q.beat.is_last  = last;
        q.gap           = steady ? 0 : $urandom_range(0, 15);
        q.drain_first   = drain;
        send_queue.push_back(q);
    endtask

    // Queues a list of n beats with random tags; only the final one is marked last.
    task automatic add_list(int unsigned n, key_spread_t spread, bit steady, bit drain);
        logic [15:0] key;
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            case (spread)
                SPREAD_TIES:  key = 16'($urandom_range(0, 3));
                SPREAD_EDGES:
                    case ($urandom_range(0, 3))
                        0:       key = 16'h0000;
                        1:       key = 16'hFFFF;
                        2:       key = 16'h7FFF;
                        default: key = 16'h8000;
                    endcase
                default:      key = 16'($urandom);
            endcase
            add_beat(key, 9'($urandom_range(0, 511)), i + 1 == n, steady, drain && i == 0);
        end
    endtask

    // Monitor: everything is sampled at the rising edge, where the block's outputs still
    // hold the values of the cycle that ends there.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_taken   <= item_valid && item_ready;
            result_taken <= result_valid && result_ready;
            if (item_valid && item_ready)
            begin
                place_beat(item_beat);
                beats_taken++;
            end
            if (result_valid && result_ready)
                check_result(result_beat);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Driver: at the falling edge, once the slot is free (nothing shown, or the beat just
    // taken), it either idles out the gap drawn for the next beat or shows that beat.
    // A beat marked to drain first stays back until the receiver has every result.
    // Valid and payload are assigned once per edge, so back-to-back beats never glitch.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (gap_left > 0)
            begin
                item_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (send_queue.size() > 0
                     && !(send_queue[0].drain_first && due_results.size() > 0))
            begin
                item_beat  <= send_queue[0].beat;
                item_valid <= 1'b1;
                gap_left   <= (send_queue.size() > 1) ? send_queue[1].gap : 0;
                void'(send_queue.pop_front());
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Receiver: after every accepted result it draws a random stall, unless it is in a
    // steady stretch. It now and then switches between the two behaviors.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_now = stall_left;
            if (result_taken)
            begin
                if ($urandom_range(0, 15) == 0)
                    steady_sink = !steady_sink;
                stall_now = steady_sink ? 0 : $urandom_range(0, 15);
            end
            if (stall_now > 0)
            begin
                result_ready <= 1'b0;
                stall_left   <= stall_now - 1;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left   <= 0;
            end
        end
    end

    initial
    begin
        bit timed_out;
        timed_out = 1'b0;

        // Directed lists. The smallest list, one beat at the low extreme, then one at the
        // high extreme held back until the first run is fully out.
        add_beat(16'h0000, 9'h000, 1'b1, 1'b1, 1'b0);
        add_beat(16'hFFFF, 9'h1FF, 1'b1, 1'b0, 1'b1);
        // Equal keys must leave in arrival order, around a smaller key.
        add_beat(16'h0005, 9'h00A, 1'b0, 1'b1, 1'b0);
        add_beat(16'h0005, 9'h00B, 1'b0, 1'b1, 1'b0);
        add_beat(16'h0003, 9'h00C, 1'b0, 1'b1, 1'b0);
        add_beat(16'h0005, 9'h00D, 1'b1, 1'b1, 1'b0);
        // Strictly descending keys make every new beat travel to the bottom of the chain.
        add_beat(16'hFFFF, 9'h001, 1'b0, 1'b0, 1'b0);
        add_beat(16'h8000, 9'h002, 1'b0, 1'b0, 1'b0);
        add_beat(16'h7FFF, 9'h003, 1'b0, 1'b0, 1'b0);
        add_beat(16'h0001, 9'h004, 1'b0, 1'b0, 1'b0);
        add_beat(16'h0000, 9'h005, 1'b1, 1'b0, 1'b0);
        // Ascending keys stay where they land, with alternating tag bit patterns.
        add_beat(16'h0000, 9'h1FF, 1'b0, 1'b1, 1'b0);
        add_beat(16'h0001, 9'h100, 1'b0, 1'b1, 1'b0);
        add_beat(16'hFFFE, 9'h0AA, 1'b0, 1'b1, 1'b0);
        add_beat(16'hFFFF, 9'h155, 1'b1, 1'b1, 1'b0);
        // Ties at the top key.
        add_beat(16'hFFFF, 9'h007, 1'b0, 1'b1, 1'b0);
        add_beat(16'hFFFF, 9'h008, 1'b1, 1'b1, 1'b0);

        // Random short lists, then one list that overruns the chain by two beats so that
        // both an ordinary beat and the last beat are dropped, then short lists again to
        // see that the overflow mark clears.
        while (send_queue.size() < 35)
            add_list($urandom_range(1, 8), key_spread_t'($urandom_range(0, 2)),
                     $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
        add_list(MAX_ITEMS + 2, SPREAD_TIES, 1'b0, 1'b1);
        while (send_queue.size() < 110)
            add_list($urandom_range(1, 8), key_spread_t'($urandom_range(0, 2)),
                     $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fork
            begin
                while (send_queue.size() > 0 || item_valid || due_results.size() > 0)
                    @(posedge clk);
                repeat (TAIL_CYCLES) @(posedge clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (timed_out)
        begin
            $display("No beat accepted for %0d cycles, %0d results still owed.",
                     IDLE_LIMIT, due_results.size());
            $display("== FAIL ==");
        end
        else
        begin
            $display("Sorted %0d lists from %0d input beats, %0d of them overflowing.",
                     runs_done, beats_taken, overflow_runs);
            $display("Checked %0d result beats, %0d mismatches.",
                     results_checked, mismatches);
            if (mismatches == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pse_pkg.sv
hw/rtl/pse_cell.sv
hw/rtl/probability_sort_engine_unit.sv
bench/probability_sort_engine_unit_test.sv
